/* src/assert_macros.svh */
// Concurrent assertion helpers for the decoder checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset
`define QD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("qdec assertion failed");

// Check on every rising edge, reset included
`define QD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("qdec assertion failed during or after reset");

`endif

/* src/qdec_pkg.sv */
package qdec_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int CNT_W     = 16;
    localparam int PINS_W    = 4;
    localparam int STAT_W    = 6;

    typedef enum logic [1:0] {
        REQ_PIN_CHANGE = 2'd0,
        REQ_READ_COUNT = 2'd1,
        REQ_READ_STAT  = 2'd2,
        REQ_INIT       = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t         kind;
        logic [PINS_W-1:0] pins;
        logic              clear_counts;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status_byte;
        logic [CNT_W-1:0]  count_two;
        logic [CNT_W-1:0]  count_one;
    } result_t;

endpackage

/* src/qdec_in_stage.sv */
module qdec_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  qdec_pkg::req_t req_in,
    input  logic           take,
    output logic           req_valid,
    output qdec_pkg::req_t req_out
);

    logic           valid_reg;
    logic           valid_next;
    qdec_pkg::req_t req_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // hold the item until the core takes it
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= req_in;
        end
    end

    assign req_valid = valid_reg;
    assign req_out   = req_reg;

endmodule

/* src/qdec_core.sv */
module qdec_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    req_valid,
    input  qdec_pkg::req_t          req,
    output logic                    take,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output qdec_pkg::result_t       result
);

    logic [qdec_pkg::PINS_W-1:0] prev_pins_reg, prev_pins_next;
    logic [1:0]                  err_reg, err_next;
    logic [qdec_pkg::CNT_W-1:0]  cnt_one_reg, cnt_one_next;
    logic [qdec_pkg::CNT_W-1:0]  cnt_two_reg, cnt_two_next;
    logic                        m_valid_reg, m_valid_next;
    qdec_pkg::result_t           res_reg, res_next;

    logic                        out_free;
    logic                        has_result;
    logic                        fire;
    logic [qdec_pkg::PINS_W-1:0] diff;
    logic [qdec_pkg::CNT_W-1:0]  step_one, step_two;

    function automatic logic [qdec_pkg::CNT_W-1:0] step(
        input logic a_new, input logic b_new, input logic a_old, input logic b_old);
        logic up;
        logic dn;
        up = a_new ^ b_old;
        dn = b_new ^ a_old;
        if (up && !dn) begin
            step = qdec_pkg::CNT_W'(1);
        end else if (dn && !up) begin
            step = '1;
        end else begin
            step = '0;
        end
    endfunction

    assign out_free   = !m_valid_reg || m_tready;
    assign has_result = (req.kind == qdec_pkg::REQ_READ_COUNT) ||
                        (req.kind == qdec_pkg::REQ_READ_STAT);
    assign take       = req_valid && (!has_result || out_free);
    assign fire       = take;

    assign diff     = req.pins ^ prev_pins_reg;
    assign step_one = step(req.pins[0], req.pins[1], prev_pins_reg[0], prev_pins_reg[1]);
    assign step_two = step(req.pins[2], req.pins[3], prev_pins_reg[2], prev_pins_reg[3]);

    always_comb begin
        prev_pins_next = prev_pins_reg;
        err_next       = err_reg;
        cnt_one_next   = cnt_one_reg;
        cnt_two_next   = cnt_two_reg;
        res_next       = res_reg;
        if (fire) begin
            case (req.kind)
                qdec_pkg::REQ_PIN_CHANGE: begin
                    cnt_one_next   = cnt_one_reg + step_one;
                    cnt_two_next   = cnt_two_reg + step_two;
                    err_next       = err_reg | {&diff[3:2], &diff[1:0]};
                    prev_pins_next = req.pins;
                end
                qdec_pkg::REQ_READ_COUNT: begin
                    res_next.count_one   = cnt_one_reg;
                    res_next.count_two   = cnt_two_reg;
                    res_next.status_byte = '0;
                    if (req.clear_counts) begin
                        cnt_one_next = '0;
                        cnt_two_next = '0;
                    end
                end
                qdec_pkg::REQ_READ_STAT: begin
                    res_next.count_one   = '0;
                    res_next.count_two   = '0;
                    res_next.status_byte = {err_reg, prev_pins_reg};
                    err_next             = '0;
                end
                default: begin
                    cnt_one_next   = '0;
                    cnt_two_next   = '0;
                    err_next       = '0;
                    prev_pins_next = req.pins;
                end
            endcase
        end
    end

    assign m_valid_next = (fire && has_result) || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pins_reg <= '0;
            err_reg       <= '0;
            cnt_one_reg   <= '0;
            cnt_two_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            prev_pins_reg <= prev_pins_next;
            err_reg       <= err_next;
            cnt_one_reg   <= cnt_one_next;
            cnt_two_reg   <= cnt_two_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign result   = res_reg;

endmodule

/* src/dual_quadrature_decoder.sv */
// Channel | Direction | tdata (low bit up)                              | tuser
// s_      | in        | pins[3:0], clear_counts, 3 zero bits            | req_type[1:0]
// m_      | out       | count_one[15:0], count_two[15:0], status_byte[5:0], 2 zero bits | -
//
// One item per cycle save read stalls: input register, then decode/update, result register.
// A read item accepted at one edge shows its result from the next edge unless stalled.
// Pin-change and init items leave no result and never wait on m_tready.
// A read item waits in the input register only while the result register is full and stalled.
// aresetn clears counts, error flags, stored pins and both valid flags.
module dual_quadrature_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [qdec_pkg::S_TDATA_W-1:0]    s_tdata,   // pins[3:0], clear_counts
    input  logic [1:0]                        s_tuser,   // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qdec_pkg::M_TDATA_W-1:0]    m_tdata    // count_one, count_two, status_byte
);

    qdec_pkg::req_t    req_in;
    qdec_pkg::req_t    req_q;
    qdec_pkg::result_t result;
    logic              req_valid;
    logic              take;

    assign req_in.kind         = qdec_pkg::req_kind_t'(s_tuser);
    assign req_in.pins         = s_tdata[qdec_pkg::PINS_W-1:0];
    assign req_in.clear_counts = s_tdata[qdec_pkg::PINS_W];

    qdec_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .req_in    (req_in),
        .take      (take),
        .req_valid (req_valid),
        .req_out   (req_q)
    );

    qdec_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req       (req_q),
        .take      (take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = {2'b00, result};

endmodule

/* src/qdec_checker.sv */
`include "assert_macros.svh"

module qdec_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [qdec_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [1:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [qdec_pkg::M_TDATA_W-1:0] m_tdata
);

    `QD_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid)

    `QD_ASSERT(a_in_hold, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))

    `QD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // a result carries either counts or status, never both
    `QD_ASSERT(a_one_kind, m_tvalid |-> (m_tdata[37:32] == 6'd0 || m_tdata[31:0] == 32'd0))

    `QD_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[39:38] == 2'b00)

endmodule

bind dual_quadrature_decoder qdec_checker u_qdec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
